>>> src/random_hyperplane_sign_hash_defines.svh
// Assertion macros used by the checker of the hash block.
`ifndef RANDOM_HYPERPLANE_SIGN_HASH_DEFINES_SVH
`define RANDOM_HYPERPLANE_SIGN_HASH_DEFINES_SVH

// A property that must hold at every sampled clock edge outside reset.
`define RHSH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define RHSH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rhsh_pkg.sv
`default_nettype none

package rhsh_pkg;

  // Fixed field widths.
  localparam int OP_W         = 1;
  localparam int PLANE_IDX_W  = 4;
  localparam int ELEM_IDX_W   = 9;
  localparam int VALUE_W      = 16;
  localparam int HASH_W       = 16;
  localparam int ITEM_W       = 32;
  localparam int PROD_W       = 2 * VALUE_W;
  localparam int ACTIVE_DIM_W = 10;
  localparam int PLANES_W     = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 10;
  localparam int S_TDATA_W    = 32;
  localparam int M_TDATA_W    = 48;

  // Compare widths wide enough for the largest dimension and plane count.
  localparam int CMP_W    = 13;
  localparam int PL_CMP_W = 7;

  // Default sizes.
  localparam int DEF_NUM_PLANES = 16;
  localparam int DEF_MAX_DIM    = 512;

  // Register reset values.
  localparam logic [ACTIVE_DIM_W-1:0] ACTIVE_DIM_RST = 10'd512;
  localparam logic [PLANES_W-1:0]     PLANES_RST     = 5'd16;

  // Request kinds carried on tuser.
  localparam logic [OP_W-1:0] OP_WEIGHT  = 1'b0;
  localparam logic [OP_W-1:0] OP_ELEMENT = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_DIM    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANES_IN_USE = 1'b1;

  // Stage strobes shared by every plane lane; all but acc_last already include the advance.
  typedef struct packed {
    logic rd_en;
    logic mul_en;
    logic acc_en;
    logic acc_last;
  } lane_ctl_t;

endpackage

`default_nettype wire

>>> src/random_hyperplane_sign_hash.sv
// Channel        | Dir | Payload (lowest bits first)                       | Accepted when
// ---------------+-----+---------------------------------------------------+------------------
// s_axis         | in  | tuser: operation; tdata: plane_index,             | tvalid & tready
//                |     |   element_index, value, three zero bits           |
// m_axis         | out | tdata: hash_bits, item_number                     | tvalid & tready
// cfg            | in  | cfg_idx_i selects the register, cfg_data_i value  | cfg_we_i
//
// One request is taken every cycle while the pipeline advances. A request passes an input
// register, the weight store read (one read port per plane lane), a registered multiplier
// and the accumulator, and the finished hash is then held in the result register.
// Reset clears the accumulators, element position, item counter and valid flags; the
// weight store is not cleared and must be written before use.
// Requests stall only when a finishing vector meets a full result register that the
// sink has not taken; all other requests keep moving.
`default_nettype none

module random_hyperplane_sign_hash
  import rhsh_pkg::*;
#(
  parameter int NUM_PLANES = DEF_NUM_PLANES,
  parameter int MAX_DIM    = DEF_MAX_DIM
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Request stream.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [3:0] plane_index, [12:4] element_index, [28:13] value, [31:29] zero
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  // [0] operation
  input  wire logic [OP_W-1:0]       s_axis_tuser,
  // Result stream.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [15:0] hash_bits, [47:16] item_number
  output logic [M_TDATA_W-1:0]       m_axis_tdata,
  // Configuration writes.
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AddrW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ElemExtW = ELEM_IDX_W + AddrW;

  // Configuration registers.
  logic [ACTIVE_DIM_W-1:0] active_dim_q;
  logic [PLANES_W-1:0]     planes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_dim_q <= ACTIVE_DIM_RST;
      planes_q     <= PLANES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ACTIVE_DIM:    active_dim_q <= cfg_data_i;
        REG_PLANES_IN_USE: planes_q     <= cfg_data_i[PLANES_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective dimension and plane count, with zero and oversize values clamped.
  logic [CMP_W-1:0]    dim_ext, dim_eff;
  logic [PL_CMP_W-1:0] pl_ext, pl_eff;

  assign dim_ext = CMP_W'(active_dim_q);
  assign dim_eff = (active_dim_q == '0) ? CMP_W'(1) :
                   (dim_ext > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : dim_ext;
  assign pl_ext  = PL_CMP_W'(planes_q);
  assign pl_eff  = (planes_q == '0) ? PL_CMP_W'(1) :
                   (pl_ext > PL_CMP_W'(NUM_PLANES)) ? PL_CMP_W'(NUM_PLANES) : pl_ext;

  // The pipeline advances unless a finishing vector would overwrite an untaken result.
  logic adv;
  logic s2_valid_q, s2_last_q;
  logic out_valid_q;

  assign adv           = !(s2_valid_q && s2_last_q && out_valid_q && !m_axis_tready);
  assign s_axis_tready = adv;

  // Input register.
  logic                   s0_valid_q;
  logic [OP_W-1:0]        s0_op_q;
  logic [PLANE_IDX_W-1:0] s0_plane_q;
  logic [ELEM_IDX_W-1:0]  s0_elem_q;
  logic [VALUE_W-1:0]     s0_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      s0_op_q    <= s_axis_tuser;
      s0_plane_q <= s_axis_tdata[PLANE_IDX_W-1:0];
      s0_elem_q  <= s_axis_tdata[PLANE_IDX_W +: ELEM_IDX_W];
      s0_value_q <= s_axis_tdata[PLANE_IDX_W + ELEM_IDX_W +: VALUE_W];
    end
  end

  // Element position and end-of-vector detection.
  logic              s0_elem_go, s0_wr_go, s0_last;
  logic [AddrW-1:0]  pos_q, pos_d;
  logic [CMP_W-1:0]  pos_next;
  logic [ElemExtW-1:0] elem_ext;
  logic [AddrW-1:0]  lane_addr;
  logic              wr_in_range;

  assign s0_elem_go  = adv && s0_valid_q && (s0_op_q == OP_ELEMENT);
  assign s0_wr_go    = adv && s0_valid_q && (s0_op_q == OP_WEIGHT);
  assign pos_next    = CMP_W'(pos_q) + CMP_W'(1);
  assign s0_last     = (pos_next >= dim_eff);
  assign elem_ext    = ElemExtW'(s0_elem_q);
  assign wr_in_range = (CMP_W'(s0_elem_q) < CMP_W'(MAX_DIM));
  assign lane_addr   = (s0_op_q == OP_WEIGHT) ? elem_ext[AddrW-1:0] : pos_q;

  always_comb begin
    pos_d = pos_q;
    if (s0_elem_go) begin
      pos_d = s0_last ? '0 : pos_next[AddrW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // Read stage and multiply stage control.
  logic               s1_valid_q, s1_last_q;
  logic [VALUE_W-1:0] s1_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_last_q  <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s0_elem_go;
      s1_last_q  <= s0_last;
      s2_valid_q <= s1_valid_q;
      s2_last_q  <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_elem_go) begin
      s1_value_q <= s0_value_q;
    end
  end

  lane_ctl_t lane_ctl;

  assign lane_ctl.rd_en    = s0_elem_go;
  assign lane_ctl.mul_en   = adv && s1_valid_q;
  assign lane_ctl.acc_en   = adv && s2_valid_q;
  assign lane_ctl.acc_last = s2_last_q;

  // One lane per plane: weight store, multiplier and accumulator.
  logic [NUM_PLANES-1:0] lane_pos;

  for (genvar j = 0; j < NUM_PLANES; j++) begin : g_lane
    logic lane_wr, lane_active;

    assign lane_wr     = s0_wr_go && wr_in_range &&
                         (PL_CMP_W'(s0_plane_q) == PL_CMP_W'(j));
    assign lane_active = (PL_CMP_W'(j) < pl_eff);

    rhsh_plane_lane #(
      .MAX_DIM (MAX_DIM),
      .AddrW   (AddrW)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (lane_ctl),
      .wr_en_i    (lane_wr),
      .addr_i     (lane_addr),
      .wdata_i    (s0_value_q),
      .value_i    ($signed(s1_value_q)),
      .active_i   (lane_active),
      .positive_o (lane_pos[j])
    );
  end

  // Hash bits: planes above the output width are dropped, missing planes read zero.
  logic [HASH_W-1:0] hash_d;

  for (genvar j = 0; j < HASH_W; j++) begin : g_hash
    if (j < NUM_PLANES) begin : g_used
      assign hash_d[j] = lane_pos[j];
    end else begin : g_unused
      assign hash_d[j] = 1'b0;
    end
  end

  // Result register and item counter.
  logic              out_load;
  logic [HASH_W-1:0] hash_q;
  logic [ITEM_W-1:0] item_q, count_q;

  assign out_load = adv && s2_valid_q && s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        count_q     <= count_q + ITEM_W'(1);
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      hash_q <= hash_d;
      item_q <= count_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {item_q, hash_q};

endmodule

`default_nettype wire

>>> src/rhsh_plane_lane.sv
`default_nettype none

module rhsh_plane_lane
  import rhsh_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM,
  parameter int AddrW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire lane_ctl_t                 ctl_i,
  input  wire logic                      wr_en_i,
  input  wire logic [AddrW-1:0]          addr_i,
  input  wire logic [VALUE_W-1:0]        wdata_i,
  input  wire logic signed [VALUE_W-1:0] value_i,
  input  wire logic                      active_i,
  output logic                           positive_o
);

  localparam int AccW = PROD_W + 1 + $clog2(MAX_DIM + 1);

  logic [VALUE_W-1:0]        weight_mem_q [MAX_DIM];
  logic signed [VALUE_W-1:0] weight_q;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic signed [AccW-1:0]    acc_q, acc_d, sum_d;

  // Weight store: one port, written by weight requests, read by elements.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      weight_mem_q[addr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      weight_q <= $signed(weight_mem_q[addr_i]);
    end
  end

  assign prod_d = value_i * weight_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  assign sum_d = acc_q + AccW'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.acc_en) begin
      if (ctl_i.acc_last) begin
        acc_d = '0;
      end else if (active_i) begin
        acc_d = sum_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign positive_o = active_i && !sum_d[AccW-1] && (sum_d != '0);

endmodule

`default_nettype wire

>>> src/rhsh_checker.sv
`default_nettype none
`include "random_hyperplane_sign_hash_defines.svh"

module rhsh_checker
  import rhsh_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [M_TDATA_W-1:0]  m_axis_tdata
);

  // A held result keeps its contents until the sink takes it.
  `RHSH_ASSERT_NEXT(a_result_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // Requests are refused only while a finished result waits on the sink.
  `RHSH_ASSERT(a_stall_cause, clk_i, rst_ni, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready), "request refused without a waiting result")

  // Consecutive results carry consecutive item numbers.
  `RHSH_ASSERT_NEXT(a_item_step, clk_i, rst_ni, m_axis_tvalid && m_axis_tready, !m_axis_tvalid || (m_axis_tdata[47:16] == $past(m_axis_tdata[47:16]) + 32'd1), "item number did not step by one")

endmodule

bind random_hyperplane_sign_hash rhsh_checker u_rhsh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
